// ===== rtl/core/bdd_pkg.sv =====
// package for the buffer descriptor deque
// holds opcodes, field widths and the descriptor entry type; no dependencies
package bdd_pkg;

  localparam int DEPTH_DEFAULT = 256;
  localparam int WORDS         = 8;
  localparam int WORD_W        = 32;
  localparam int OCC_W         = 9;
  localparam int OP_W          = 2;

  typedef logic [OP_W-1:0]   opcode_t;
  typedef logic [WORD_W-1:0] word_t;
  typedef logic [OCC_W-1:0]  occ_t;
  typedef logic [WORDS-1:0][WORD_W-1:0] entry_t;

  localparam opcode_t OP_PUSH_BACK  = 2'd0;
  localparam opcode_t OP_PUSH_FRONT = 2'd1;
  localparam opcode_t OP_POP_FRONT  = 2'd2;

endpackage

// ===== rtl/core/bdd_if.sv =====
// valid/ready channel interfaces for the buffer descriptor deque
// depends on bdd_pkg
interface bdd_in_if;
  import bdd_pkg::*;
  logic    valid;
  logic    ready;
  opcode_t opcode;
  word_t   in_word0;
  word_t   in_word1;
  word_t   in_word2;
  word_t   in_word3;
  word_t   in_word4;
  word_t   in_word5;
  word_t   in_word6;
  word_t   in_word7;

  modport source (
    output valid, opcode, in_word0, in_word1, in_word2, in_word3,
           in_word4, in_word5, in_word6, in_word7,
    input  ready
  );
  modport sink (
    input  valid, opcode, in_word0, in_word1, in_word2, in_word3,
           in_word4, in_word5, in_word6, in_word7,
    output ready
  );
endinterface

interface bdd_out_if;
  import bdd_pkg::*;
  logic  valid;
  logic  ready;
  logic  success;
  word_t out_word0;
  word_t out_word1;
  word_t out_word2;
  word_t out_word3;
  word_t out_word4;
  word_t out_word5;
  word_t out_word6;
  word_t out_word7;
  occ_t  occupancy;

  modport source (
    output valid, success, out_word0, out_word1, out_word2, out_word3,
           out_word4, out_word5, out_word6, out_word7, occupancy,
    input  ready
  );
  modport sink (
    input  valid, success, out_word0, out_word1, out_word2, out_word3,
           out_word4, out_word5, out_word6, out_word7, occupancy,
    output ready
  );
endinterface

// ===== rtl/core/buffer_descriptor_deque.sv =====
// buffer descriptor deque top level: ring of descriptor entries with head and count
// depends on bdd_pkg, bdd_if and bdd_ram
//
//   channel  | dir | handshake     | payload
//   in_ch    | in  | valid/ready   | opcode, in_word0..in_word7
//   out_ch   | out | valid/ready   | success, out_word0..out_word7, occupancy
//
// one item per cycle while the result is not stalled; a result shows in the cycle after its transfer
// head, count and the write or read of one entry happen at the accepting edge
// popped words come from the memory read register, which holds while stalled
// input is taken whenever the result register is empty or being drained
// reset clears head, count and the result valid; the entry memory is not cleared
module buffer_descriptor_deque #(
  parameter int DEPTH = bdd_pkg::DEPTH_DEFAULT
) (
  input  logic      clk,
  input  logic      rst_n,
  bdd_in_if.sink    in_ch,
  bdd_out_if.source out_ch
);
  import bdd_pkg::*;

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;

  logic [IDX_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             success_r, success_nxt;
  logic             pop_r, pop_nxt;
  occ_t             occ_r, occ_nxt;

  logic             accept;
  logic             full;
  logic             empty;
  logic [IDX_W-1:0] head_dec;
  logic [IDX_W-1:0] head_inc;
  logic [SUM_W-1:0] tail_sum;
  logic [IDX_W-1:0] tail;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic             rd_en;
  entry_t           wr_data;
  entry_t           rd_data;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign head_dec = (head_r == '0) ? IDX_W'(DEPTH - 1) : head_r - 1'b1;
  assign head_inc = (head_r == IDX_W'(DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign tail_sum = SUM_W'(head_r) + SUM_W'(count_r);
  assign tail     = (tail_sum >= SUM_W'(DEPTH)) ? IDX_W'(tail_sum - SUM_W'(DEPTH))
                                                 : IDX_W'(tail_sum);

  always_comb begin
    wr_data[0] = in_ch.in_word0;
    wr_data[1] = in_ch.in_word1;
    wr_data[2] = in_ch.in_word2;
    wr_data[3] = in_ch.in_word3;
    wr_data[4] = in_ch.in_word4;
    wr_data[5] = in_ch.in_word5;
    wr_data[6] = in_ch.in_word6;
    wr_data[7] = in_ch.in_word7;
  end

  always_comb begin
    head_nxt    = head_r;
    count_nxt   = count_r;
    success_nxt = 1'b0;
    pop_nxt     = 1'b0;
    wr_en       = 1'b0;
    wr_addr     = tail;
    rd_en       = 1'b0;
    case (in_ch.opcode)
      OP_PUSH_BACK: begin
        if (!full && in_ch.in_word0 != '0 && in_ch.in_word1 != '0) begin
          success_nxt = 1'b1;
          wr_en       = accept;
          count_nxt   = count_r + 1'b1;
        end
      end
      OP_PUSH_FRONT: begin
        if (!full) begin
          success_nxt = 1'b1;
          wr_en       = accept;
          wr_addr     = head_dec;
          head_nxt    = head_dec;
          count_nxt   = count_r + 1'b1;
        end
      end
      OP_POP_FRONT: begin
        if (!empty) begin
          success_nxt = 1'b1;
          pop_nxt     = 1'b1;
          rd_en       = accept;
          head_nxt    = head_inc;
          count_nxt   = count_r - 1'b1;
        end
      end
      default: begin
        success_nxt = 1'b0;
      end
    endcase
    occ_nxt = OCC_W'(count_nxt);
  end

  always_comb begin
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        head_r  <= head_nxt;
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      success_r <= success_nxt;
      pop_r     <= pop_nxt;
      occ_r     <= occ_nxt;
    end
  end

  bdd_ram #(
    .DEPTH (DEPTH),
    .AW    (IDX_W)
  ) u_ram (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (head_r),
    .rd_data_r (rd_data)
  );

  assign out_ch.valid     = out_valid_r;
  assign out_ch.success   = success_r;
  assign out_ch.occupancy = occ_r;
  assign out_ch.out_word0 = pop_r ? rd_data[0] : '0;
  assign out_ch.out_word1 = pop_r ? rd_data[1] : '0;
  assign out_ch.out_word2 = pop_r ? rd_data[2] : '0;
  assign out_ch.out_word3 = pop_r ? rd_data[3] : '0;
  assign out_ch.out_word4 = pop_r ? rd_data[4] : '0;
  assign out_ch.out_word5 = pop_r ? rd_data[5] : '0;
  assign out_ch.out_word6 = pop_r ? rd_data[6] : '0;
  assign out_ch.out_word7 = pop_r ? rd_data[7] : '0;

endmodule

// ===== rtl/core/bdd_ram.sv =====
// descriptor entry memory, one write port and one registered read port
// depends on bdd_pkg for the entry type
module bdd_ram #(
  parameter int DEPTH = bdd_pkg::DEPTH_DEFAULT,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  bdd_pkg::entry_t wr_data,
  input  logic            rd_en,
  input  logic [AW-1:0]   rd_addr,
  output bdd_pkg::entry_t rd_data_r
);
  import bdd_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/bdd_checker.sv =====
// port-level checks for the buffer descriptor deque, bound to the top level
// depends on bdd_pkg and buffer_descriptor_deque
module bdd_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input logic           success,
  input bdd_pkg::word_t out_word0,
  input bdd_pkg::word_t out_word1,
  input bdd_pkg::word_t out_word2,
  input bdd_pkg::word_t out_word3,
  input bdd_pkg::word_t out_word4,
  input bdd_pkg::word_t out_word5,
  input bdd_pkg::word_t out_word6,
  input bdd_pkg::word_t out_word7
);
  import bdd_pkg::*;

  logic words_zero;

  assign words_zero = (out_word0 == '0) && (out_word1 == '0) && (out_word2 == '0) &&
                      (out_word3 == '0) && (out_word4 == '0) && (out_word5 == '0) &&
                      (out_word6 == '0) && (out_word7 == '0);

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_transfer_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("no result after input transfer");

  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  a_refused_zero_words: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !success |-> words_zero)
    else $error("nonzero words on refused operation");

endmodule

bind buffer_descriptor_deque bdd_checker u_bdd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .success   (out_ch.success),
  .out_word0 (out_ch.out_word0),
  .out_word1 (out_ch.out_word1),
  .out_word2 (out_ch.out_word2),
  .out_word3 (out_ch.out_word3),
  .out_word4 (out_ch.out_word4),
  .out_word5 (out_ch.out_word5),
  .out_word6 (out_ch.out_word6),
  .out_word7 (out_ch.out_word7)
);
